FILE: rtl/sm3_message_hash_defines.svh
// assertion macros shared by the sm3 checker
`ifndef SM3_MESSAGE_HASH_DEFINES_SVH
`define SM3_MESSAGE_HASH_DEFINES_SVH
// assert that a condition implies a result in the same cycle
`define SM3_ASSERT_IMP(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (res)) \
        else $error("sm3 check failed");
// assert that a condition implies a result in the next cycle
`define SM3_ASSERT_NEXT(label, clk, rst_n, cond, res) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (res)) \
        else $error("sm3 check failed");
`endif

FILE: rtl/sm3_pkg.sv
// shared types and constants of the sm3 hash block
`timescale 1ns / 1ps
package sm3_pkg;
    localparam logic [31:0] T_LOW = 32'h79CC4519;
    localparam logic [31:0] T_HIGH = 32'h7A879D8A;
    localparam logic [7:0] PAD_BYTE = 8'h80;
    localparam logic [5:0] LEN_LIMIT = 6'd55;
    localparam logic [255:0] IV = {32'h7380166f, 32'h4914b2b9, 32'h172442d7, 32'hda8a0600,
        32'ha96f30bc, 32'h163138aa, 32'he38dee4d, 32'hb0fb0e4e};

    // commands from the controller to the datapath
    typedef struct packed {
        logic put_byte;     // write data byte at position, count length
        logic put_pad;      // write pad byte at position, clear rest of word
        logic zero_word;    // clear word at word counter
        logic put_len;      // write bit length into words 14 and 15
        logic clear_all;    // clear whole buffer
        logic start_block;  // load working regs from chain, reset round
        logic round;        // run one round
        logic finish_block; // fold working regs into chain
        logic reset_msg;    // chain to iv, length and position to zero
        logic shift_out;    // rotate chain for digest output
    } sm3_cmd_t;

    // status from the datapath to the controller
    typedef struct packed {
        logic [5:0] position;
        logic       last_round;
    } sm3_stat_t;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction
endpackage

FILE: rtl/sm3_message_hash.sv
// top level of the sm3 message hash block
`timescale 1ns / 1ps
// SM3 hash, one message byte per transfer; last ends the message and an empty
// last transfer (byte_present low) allows zero-length messages. The 64th byte
// of a block starts a compression (load, 64 rounds of the single round unit,
// fold). At the end, padding (pad byte, zeroed words, length words) takes one
// or two compressions, then the eight digest words leave as eight transfers,
// word 0 first, digest_last on word 7. Input is held off while padding runs, a
// block compresses or the digest is out.
module sm3_message_hash
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        byte_present,
    input  logic        last,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        digest_last
);
    sm3_pkg::sm3_cmd_t  cmd;
    sm3_pkg::sm3_stat_t stat;
    logic [3:0]         word_sel;

    sm3_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .byte_present (byte_present),
        .last         (last),
        .stat         (stat),
        .cmd          (cmd),
        .word_sel     (word_sel),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .word_index   (word_index),
        .digest_last  (digest_last)
    );

    sm3_datapath u_dp
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .word_sel   (word_sel),
        .data_byte  (data_byte),
        .stat       (stat),
        .chain_word (digest_word)
    );
endmodule

FILE: rtl/sm3_datapath.sv
// sm3 datapath: block buffer, message expansion window, round unit, chain value
`timescale 1ns / 1ps
module sm3_datapath
(
    input  logic              clk,
    input  logic              rst_n,
    input  sm3_pkg::sm3_cmd_t cmd,
    input  logic [3:0]        word_sel,
    input  logic [7:0]        data_byte,
    output sm3_pkg::sm3_stat_t stat,
    output logic [31:0]       chain_word
);
    logic [31:0] buf_reg [16];
    logic [31:0] win_reg [16];
    logic [31:0] wrk_reg [8];
    logic [31:0] chain_reg [8];
    logic [5:0]  pos_reg;
    logic [63:0] len_reg;
    logic [5:0]  rnd_reg;

    // round logic
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tc, wj, wnew, t;
    logic        lowr;
    always_comb
    begin
        lowr = (rnd_reg < 6'd16);
        tc   = lowr ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
        a12  = sm3_pkg::rotl(wrk_reg[0], 5'd12);
        ss1  = sm3_pkg::rotl(a12 + wrk_reg[4] + sm3_pkg::rotl(tc, rnd_reg[4:0]), 5'd7);
        ss2  = ss1 ^ a12;
        if (lowr)
        begin
            ff = wrk_reg[0] ^ wrk_reg[1] ^ wrk_reg[2];
            gg = wrk_reg[4] ^ wrk_reg[5] ^ wrk_reg[6];
        end
        else
        begin
            ff = (wrk_reg[0] & wrk_reg[1]) | (wrk_reg[0] & wrk_reg[2]) |
                 (wrk_reg[1] & wrk_reg[2]);
            gg = (wrk_reg[4] & wrk_reg[5]) | (~wrk_reg[4] & wrk_reg[6]);
        end
        wj   = win_reg[0];
        tt1  = ff + wrk_reg[3] + ss2 + (wj ^ win_reg[4]);
        tt2  = gg + wrk_reg[7] + ss1 + wj;
        // expansion word w[j+16], shifted into window slot 15
        t    = win_reg[0] ^ win_reg[7] ^ sm3_pkg::rotl(win_reg[13], 5'd15);
        wnew = t ^ sm3_pkg::rotl(t, 5'd15) ^ sm3_pkg::rotl(t, 5'd23) ^
               sm3_pkg::rotl(win_reg[3], 5'd7) ^ win_reg[10];
    end

    // byte lane insert
    logic [31:0] bmask, bval, pmask, pval;
    logic [1:0]  lane;
    always_comb
    begin
        lane  = pos_reg[1:0];
        bmask = 32'hFF00_0000 >> {lane, 3'b000};
        bval  = {data_byte, 24'h0} >> {lane, 3'b000};
        pmask = 32'hFFFF_FFFF >> {lane, 3'b000};
        pval  = {sm3_pkg::PAD_BYTE, 24'h0} >> {lane, 3'b000};
    end

    // block buffer
    always_ff @(posedge clk)
    begin
        if (cmd.put_byte)
            buf_reg[pos_reg[5:2]] <= (buf_reg[pos_reg[5:2]] & ~bmask) | bval;
        if (cmd.put_pad)
            buf_reg[pos_reg[5:2]] <= (buf_reg[pos_reg[5:2]] & ~pmask) | pval;
        if (cmd.zero_word)
            buf_reg[word_sel] <= 32'h0;
        if (cmd.clear_all)
            for (int i = 0; i < 16; i++)
                buf_reg[i] <= 32'h0;
        if (cmd.put_len)
        begin
            buf_reg[14] <= len_reg[63:32];
            buf_reg[15] <= len_reg[31:0];
        end
    end

    // expansion window and working registers
    always_ff @(posedge clk)
    begin
        if (cmd.start_block)
        begin
            for (int i = 0; i < 16; i++)
                win_reg[i] <= buf_reg[i];
            for (int i = 0; i < 8; i++)
                wrk_reg[i] <= chain_reg[i];
        end
        else if (cmd.round)
        begin
            for (int i = 0; i < 15; i++)
                win_reg[i] <= win_reg[i + 1];
            win_reg[15] <= wnew;
            wrk_reg[0] <= tt1;
            wrk_reg[1] <= wrk_reg[0];
            wrk_reg[2] <= sm3_pkg::rotl(wrk_reg[1], 5'd9);
            wrk_reg[3] <= wrk_reg[2];
            wrk_reg[4] <= tt2 ^ sm3_pkg::rotl(tt2, 5'd9) ^ sm3_pkg::rotl(tt2, 5'd17);
            wrk_reg[5] <= wrk_reg[4];
            wrk_reg[6] <= sm3_pkg::rotl(wrk_reg[5], 5'd19);
            wrk_reg[7] <= wrk_reg[6];
        end
    end

    // chain, length, position and round counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= sm3_pkg::IV[255 - 32*i -: 32];
            pos_reg <= '0;
            len_reg <= '0;
            rnd_reg <= '0;
        end
        else
        begin
            if (cmd.put_byte)
            begin
                pos_reg <= pos_reg + 6'd1;
                len_reg <= len_reg + 64'd8;
            end
            if (cmd.start_block)
                rnd_reg <= '0;
            else if (cmd.round)
                rnd_reg <= rnd_reg + 6'd1;
            if (cmd.finish_block)
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] ^ wrk_reg[i];
            if (cmd.shift_out)
            begin
                for (int i = 0; i < 7; i++)
                    chain_reg[i] <= chain_reg[i + 1];
                chain_reg[7] <= chain_reg[0];
            end
            if (cmd.reset_msg)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= sm3_pkg::IV[255 - 32*i -: 32];
                pos_reg <= '0;
                len_reg <= '0;
            end
        end
    end

    assign stat.position   = pos_reg;
    assign stat.last_round = (rnd_reg == 6'd63);
    assign chain_word      = chain_reg[0];
endmodule

FILE: rtl/sm3_ctrl.sv
// sm3 controller: sequences byte intake, padding, compression and digest output
`timescale 1ns / 1ps
module sm3_ctrl
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic               byte_present,
    input  logic               last,
    input  sm3_pkg::sm3_stat_t stat,
    output sm3_pkg::sm3_cmd_t  cmd,
    output logic [3:0]         word_sel,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [2:0]         word_index,
    output logic               digest_last
);
    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_PAD   = 4'd1;
    localparam logic [3:0] S_ZERO  = 4'd2;
    localparam logic [3:0] S_LEN   = 4'd3;
    localparam logic [3:0] S_START = 4'd4;
    localparam logic [3:0] S_ROUND = 4'd5;
    localparam logic [3:0] S_FOLD  = 4'd6;
    localparam logic [3:0] S_OUT   = 4'd7;

    logic [3:0] state_reg, state_next;
    logic       fin_reg, fin_next;     // block run belongs to finishing
    logic       extra_reg, extra_next; // padding needs a second block
    logic       endm_reg, endm_next;   // message end after current block
    logic [3:0] wsel_reg, wsel_next;
    logic [2:0] idx_reg, idx_next;

    always_comb
    begin
        state_next = state_reg;
        fin_next   = fin_reg;
        extra_next = extra_reg;
        endm_next  = endm_reg;
        wsel_next  = wsel_reg;
        idx_next   = idx_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.put_byte = byte_present;
                    endm_next    = last;
                    if (byte_present && stat.position == 6'd63)
                    begin
                        fin_next   = 1'b0;
                        state_next = S_START;
                    end
                    else if (last)
                        state_next = S_PAD;
                end
            end
            S_PAD:
            begin
                cmd.put_pad = 1'b1;
                extra_next  = (stat.position > sm3_pkg::LEN_LIMIT);
                wsel_next   = stat.position[5:2] + 4'd1;
                fin_next    = 1'b1;
                state_next  = (stat.position[5:2] == 4'd15) ? S_START : S_ZERO;
            end
            S_ZERO:
            begin
                cmd.zero_word = 1'b1;
                wsel_next     = wsel_reg + 4'd1;
                if (wsel_reg == 4'd15)
                    state_next = extra_reg ? S_START : S_LEN;
            end
            S_LEN:
            begin
                cmd.put_len = 1'b1;
                state_next  = S_START;
            end
            S_START:
            begin
                cmd.start_block = 1'b1;
                state_next      = S_ROUND;
            end
            S_ROUND:
            begin
                cmd.round = 1'b1;
                if (stat.last_round)
                    state_next = S_FOLD;
            end
            S_FOLD:
            begin
                cmd.finish_block = 1'b1;
                if (!fin_reg)
                    state_next = endm_reg ? S_PAD : S_IDLE;
                else if (extra_reg)
                begin
                    cmd.clear_all = 1'b1;
                    extra_next    = 1'b0;
                    state_next    = S_LEN;
                end
                else
                begin
                    idx_next   = '0;
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                out_valid = 1'b1;
                if (out_ready)
                begin
                    cmd.shift_out = 1'b1;
                    idx_next      = idx_reg + 3'd1;
                    if (idx_reg == 3'd7)
                    begin
                        cmd.shift_out = 1'b0;
                        cmd.reset_msg = 1'b1;
                        state_next    = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            fin_reg   <= 1'b0;
            extra_reg <= 1'b0;
            endm_reg  <= 1'b0;
            wsel_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            fin_reg   <= fin_next;
            extra_reg <= extra_next;
            endm_reg  <= endm_next;
            wsel_reg  <= wsel_next;
            idx_reg   <= idx_next;
        end
    end

    assign word_sel    = wsel_reg;
    assign word_index  = idx_reg;
    assign digest_last = (idx_reg == 3'd7);
endmodule

FILE: rtl/sm3_message_hash_checker.sv
// port level checker for the sm3 hash block, with its bind
`timescale 1ns / 1ps
`include "sm3_message_hash_defines.svh"
module sm3_message_hash_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        digest_last
);
    `SM3_ASSERT_IMP(a_last_flag, clk, rst_n, out_valid, digest_last == (word_index == 3'd7))
    `SM3_ASSERT_IMP(a_no_overlap, clk, rst_n, out_valid, !in_ready)
    `SM3_ASSERT_NEXT(a_index_step, clk, rst_n, out_valid && out_ready && !digest_last,
        out_valid && word_index == $past(word_index) + 3'd1)
    `SM3_ASSERT_NEXT(a_hold, clk, rst_n, out_valid && !out_ready,
        out_valid && $stable(digest_word))
endmodule

bind sm3_message_hash sm3_message_hash_checker u_checker
(
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .digest_word (digest_word),
    .word_index  (word_index),
    .digest_last (digest_last)
);

FILE: test/sm3_message_hash_tb.sv
// testbench for the sm3 message hash block: streamed messages checked against a local sm3 predictor
`timescale 1ns / 1ps
module sm3_message_hash_tb;

    // expected digest word
    typedef struct {
        logic [31:0] word;
        logic [2:0]  index;
        logic        is_last;
    } digest_entry_t;

    // sm3 predictor and store of expected digest words
    class sm3_scoreboard;
        logic [31:0] chain [8];
        logic [31:0] block [16];
        logic [5:0]  position;
        logic [63:0] bit_count;
        digest_entry_t pending [$];
        int errors;

        function new();
            errors = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
                chain[i] = sm3_pkg::IV[255 - 32 * i -: 32];
            for (int i = 0; i < 16; i++)
                block[i] = '0;
            position = '0;
            bit_count = '0;
        endfunction

        function logic [31:0] rol(logic [31:0] x, int n);
            int k;
            k = n % 32;
            if (k == 0)
                return x;
            return (x << k) | (x >> (32 - k));
        endfunction

        function void store_byte(logic [5:0] pos, logic [7:0] b);
            block[pos[5:2]][(3 - pos[1:0]) * 8 +: 8] = b;
        endfunction

        function void compress();
            logic [31:0] w [68];
            logic [31:0] r [8];
            logic [31:0] t, a12, ss1, ss2, ff, gg, tt1, tt2, tc;
            for (int j = 0; j < 16; j++)
                w[j] = block[j];
            for (int j = 16; j < 68; j++)
            begin
                t = w[j - 16] ^ w[j - 9] ^ rol(w[j - 3], 15);
                w[j] = t ^ rol(t, 15) ^ rol(t, 23) ^ rol(w[j - 13], 7) ^ w[j - 6];
            end
            for (int j = 0; j < 8; j++)
                r[j] = chain[j];
            for (int j = 0; j < 64; j++)
            begin
                tc = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
                a12 = rol(r[0], 12);
                ss1 = rol(a12 + r[4] + rol(tc, j), 7);
                ss2 = ss1 ^ a12;
                if (j < 16)
                begin
                    ff = r[0] ^ r[1] ^ r[2];
                    gg = r[4] ^ r[5] ^ r[6];
                end
                else
                begin
                    ff = (r[0] & r[1]) | (r[0] & r[2]) | (r[1] & r[2]);
                    gg = (r[4] & r[5]) | (~r[4] & r[6]);
                end
                tt1 = ff + r[3] + ss2 + (w[j] ^ w[j + 4]);
                tt2 = gg + r[7] + ss1 + w[j];
                r[3] = r[2];
                r[2] = rol(r[1], 9);
                r[1] = r[0];
                r[0] = tt1;
                r[7] = r[6];
                r[6] = rol(r[5], 19);
                r[5] = r[4];
                r[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
            end
            for (int j = 0; j < 8; j++)
                chain[j] ^= r[j];
        endfunction

        // note one accepted input transfer
        function void note_input(logic [7:0] data, logic present, logic fin);
            digest_entry_t e;
            logic [5:0] p;
            if (present)
            begin
                store_byte(position, data);
                bit_count += 64'd8;
                position += 6'd1;
                if (position == 6'd0)
                    compress();
            end
            if (!fin)
                return;
            // padding, with an extra block when the length does not fit
            p = position;
            store_byte(p, sm3_pkg::PAD_BYTE);
            for (int i = p + 1; i < 64; i++)
                store_byte(i[5:0], 8'h00);
            if (p > sm3_pkg::LEN_LIMIT)
            begin
                compress();
                for (int i = 0; i < 16; i++)
                    block[i] = '0;
            end
            block[14] = bit_count[63:32];
            block[15] = bit_count[31:0];
            compress();
            for (int i = 0; i < 8; i++)
            begin
                e.word = chain[i];
                e.index = i[2:0];
                e.is_last = (i == 7);
                pending.push_back(e);
            end
            for (int i = 0; i < 8; i++)
                chain[i] = sm3_pkg::IV[255 - 32 * i -: 32];
            position = '0;
            bit_count = '0;
        endfunction

        // check one accepted digest word
        task check_output(logic [31:0] word, logic [2:0] index, logic is_last);
            digest_entry_t e;
            if (pending.size() == 0)
            begin
                report_mismatch($sformatf("unexpected digest word %h", word));
                return;
            end
            e = pending.pop_front();
            if (word !== e.word)
                report_mismatch($sformatf("digest_word %h, want %h", word, e.word));
            if (index !== e.index)
                report_mismatch($sformatf("word_index %0d, want %0d", index, e.index));
            if (is_last !== e.is_last)
                report_mismatch($sformatf("digest_last %b, want %b", is_last, e.is_last));
        endtask

        task report_mismatch(string msg);
            errors++;
            $display("mismatch: %s", msg);
        endtask
    endclass

    logic        clk;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  data_byte;
    logic        byte_present;
    logic        last;
    logic        out_valid;
    logic        out_ready;
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        digest_last;

    sm3_scoreboard hash_model;
    int cycle_count;
    bit out_idle_free;

    localparam int CYCLE_LIMIT = 1500000;

    sm3_message_hash u_dut
    (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .data_byte(data_byte),
        .byte_present(byte_present),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .digest_word(digest_word),
        .word_index(word_index),
        .digest_last(digest_last)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #2;
        clk = 1'b1;
        #2;
    end

    // gap before a transfer: often none, otherwise a random draw
    function automatic int draw_gap();
        if ($urandom_range(0, 3) == 0)
            return 0;
        return $urandom_range(0, 16);
    endfunction

    // send one input transfer and wait for its acceptance
    task automatic send_item(logic [7:0] data, logic present, logic fin, bit use_gap);
        int gap;
        gap = use_gap ? draw_gap() : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap)
                @(posedge clk);
        end
        in_valid <= 1'b1;
        data_byte <= data;
        byte_present <= present;
        last <= fin;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        hash_model.note_input(data, present, fin);
    endtask

    // send a message of random bytes, with occasional idle transfers
    task automatic send_message(int len, bit empty_end, bit use_gap);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(0, 15) == 0)
                send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0, use_gap);
            if (i == len - 1 && !empty_end)
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1, use_gap);
            else
                send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0, use_gap);
        end
        if (empty_end || len == 0)
            send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1, use_gap);
    endtask

    // receiver with random stalls
    initial
    begin
        int gap;
        out_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            gap = out_idle_free ? 0 : draw_gap();
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap)
                    @(posedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid)
                @(posedge clk);
            hash_model.check_output(digest_word, word_index, digest_last);
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout");
            $display("Some tests failed");
            $finish;
        end
    end

    initial
    begin
        int n;
        hash_model = new();
        cycle_count = 0;
        out_idle_free = 1'b0;
        rst_n = 1'b0;
        in_valid = 1'b0;
        data_byte = 8'h00;
        byte_present = 1'b0;
        last = 1'b0;
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty message, "abc", extremes, padding boundaries
        send_item(8'h00, 1'b0, 1'b1, 1'b0);
        send_item(8'h61, 1'b1, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b0, 1'b0);
        send_item(8'h62, 1'b1, 1'b0, 1'b0);
        send_item(8'h63, 1'b1, 1'b1, 1'b0);
        send_item(8'hff, 1'b1, 1'b1, 1'b0);
        send_item(8'h00, 1'b1, 1'b0, 1'b0);
        send_item(8'h55, 1'b0, 1'b1, 1'b0);
        send_message(55, 1'b0, 1'b0);
        send_message(56, 1'b1, 1'b0);
        send_message(64, 1'b0, 1'b0);
        send_message(64, 1'b1, 1'b0);

        // random messages, mostly short, a few spanning blocks
        n = 0;
        while (n < 50)
        begin
            int len;
            out_idle_free = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 5) == 0)
                len = $urandom_range(50, 130);
            else
                len = $urandom_range(0, 20);
            send_message(len, 1'($urandom_range(0, 1)), ($urandom_range(0, 4) != 0));
            n += len + 1;
        end
        in_valid <= 1'b0;
        out_idle_free = 1'b0;

        while (hash_model.pending.size() != 0)
            @(posedge clk);
        repeat (200)
            @(posedge clk);
        if (hash_model.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
